### design/interleaved_audio_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Concurrent check wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INTERLEAVED_AUDIO_FRAME_DEFRAMER_ASSERT_SVH
`define INTERLEAVED_AUDIO_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define IAFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("deframer check failed");
`define IAFD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer check failed");
`define IAFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer check failed");
`else
`define IAFD_ASSERT(lbl, prop)
`define IAFD_ASSERT_IMPL(lbl, ante, cons)
`define IAFD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### design/iafd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Result codes, parser phases, register indexes and shared record types.
// ----------------------------------------------------------------------------
`default_nettype none

package iafd_pkg;

  localparam logic [1:0] KindHdr  = 2'd0;
  localparam logic [1:0] KindMpeg = 2'd1;
  localparam logic [1:0] KindPcm  = 2'd2;
  localparam logic [1:0] KindErr  = 2'd3;

  localparam logic [2:0] PhHdrLo = 3'd0;
  localparam logic [2:0] PhHdrHi = 3'd1;
  localparam logic [2:0] PhCnt0  = 3'd2;
  localparam logic [2:0] PhCnt1  = 3'd3;
  localparam logic [2:0] PhCnt2  = 3'd4;
  localparam logic [2:0] PhCnt3  = 3'd5;
  localparam logic [2:0] PhBody  = 3'd6;

  localparam logic [1:0] CfgChannels = 2'd0;
  localparam logic [1:0] CfgStreams  = 2'd1;
  localparam logic [1:0] CfgSelect   = 2'd2;

  localparam int QDepth = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] data;
    logic [11:0] count;
    logic [12:0] length;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } push_t;

  typedef struct packed {
    logic       error;
    logic [2:0] phase;
  } stat_t;

endpackage

`default_nettype wire

### design/interleaved_audio_frame_deframer.sv
// ----------------------------------------------------------------------------
// Interleaved audio frame deframer
// Splits a framed byte stream into header, MPEG byte and PCM sample items.
// ----------------------------------------------------------------------------
// One stream byte enters per item on the input channel (in_valid_i, in_stall_o,
// data_byte_i). Frames are parsed in order and assigned round robin to streams;
// only the selected stream's frames yield output items, errors always do.
// The parser takes one byte per cycle with no gaps while in_stall_o is low;
// a byte that produces an item has it registered into the two-entry queue,
// whose head drives out_valid_o; throughput 1 item per cycle without stalls.
// When the receiver stalls, the queue holds up to two items; once full,
// in_stall_o rises until an item leaves. Bytes that give no item never wait
// on the output side unless the queue is full.
// Configuration (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i) is always
// ready; the user writes it only while idle; the block does not enforce that.
// Reset clears the parser to wait for a header, empties the queue, clears the
// sticky error and restores one channel, one stream, stream zero selected.
// ----------------------------------------------------------------------------
`default_nettype none

`include "interleaved_audio_frame_deframer_assert.svh"

module interleaved_audio_frame_deframer #(
  parameter int MAX_STREAMS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [3:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         data_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              out_kind_o,
  output logic [7:0]              mpeg_byte_o,
  output logic signed [15:0]      pcm_sample_o,
  output logic [11:0]             pcm_count_o,
  output logic [12:0]             mpeg_length_o,
  output logic                    frame_last_o
);

  iafd_pkg::push_t push;
  iafd_pkg::stat_t stat;
  logic            full;
  logic            take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign take        = in_valid_i && !full;

  iafd_front #(
    .MaxStreams(MAX_STREAMS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .take_i     (take),
    .data_byte_i(data_byte_i),
    .push_o     (push),
    .stat_o     (stat)
  );

  iafd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_kind_o   (out_kind_o),
    .mpeg_byte_o  (mpeg_byte_o),
    .pcm_sample_o (pcm_sample_o),
    .pcm_count_o  (pcm_count_o),
    .mpeg_length_o(mpeg_length_o),
    .frame_last_o (frame_last_o)
  );

  `IAFD_ASSERT_IMPL(a_stall_only_full, in_stall_o, out_valid_o)
  `IAFD_ASSERT_NEXT(a_error_sticky, stat.error, stat.error)
  `IAFD_ASSERT_NEXT(a_error_emits, take && stat.error, out_valid_o)
  `IAFD_ASSERT(a_error_clean, !(out_valid_o && out_kind_o == iafd_pkg::KindErr && frame_last_o))
  `IAFD_ASSERT(a_phase_legal, stat.phase <= iafd_pkg::PhBody)

endmodule

`default_nettype wire

### design/iafd_front.sv
// ----------------------------------------------------------------------------
// Deframer front end
// Parses the byte stream into frames, tracks the stream slot and emits records.
// ----------------------------------------------------------------------------
`default_nettype none

module iafd_front #(
  parameter int MaxStreams = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [3:0]        cfg_data_i,
  input  wire logic              take_i,
  input  wire logic [7:0]        data_byte_i,
  output iafd_pkg::push_t        push_o,
  output iafd_pkg::stat_t        stat_o
);

  localparam int SlotW = (MaxStreams > 1) ? $clog2(MaxStreams) : 1;
  localparam int EffW  = ($clog2(MaxStreams + 1) > 4) ? $clog2(MaxStreams + 1) : 4;
  localparam int CmpW  = (SlotW > 3) ? SlotW : 3;

  logic [1:0]       cpf_q;
  logic [3:0]       sc_q;
  logic [2:0]       sel_q;

  logic [2:0]       phase_q, phase_d;
  logic [12:0]      hdr_q, hdr_d;
  logic [11:0]      cnt_q, cnt_d;
  logic             big_q, big_d;
  logic [13:0]      pcm_q, pcm_d;
  logic [12:0]      left_q, left_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [7:0]       low_q, low_d;
  logic             err_q, err_d;

  logic [EffW-1:0]  eff;
  logic [EffW-1:0]  slot_inc;
  logic [SlotW-1:0] slot_nx;
  logic             sel;

  logic             fin_ext;
  logic [11:0]      fin_count;
  logic [13:0]      fin_pcm;
  logic [12:0]      fin_size;
  logic [14:0]      fin_pre;
  logic [14:0]      fin_need;
  logic             fin_bad;
  logic [14:0]      fin_left_w;
  logic [12:0]      fin_left;
  logic [12:0]      fin_mpeg;
  logic             do_fin;
  logic             in_pcm;
  logic             last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpf_q <= 2'd1;
      sc_q  <= 4'd1;
      sel_q <= 3'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        iafd_pkg::CfgChannels: cpf_q <= cfg_data_i[1:0];
        iafd_pkg::CfgStreams:  sc_q  <= cfg_data_i;
        iafd_pkg::CfgSelect:   sel_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff = EffW'(sc_q);
    if (sc_q == 4'd0) begin
      eff = EffW'(1);
    end else if (EffW'(sc_q) > EffW'(MaxStreams)) begin
      eff = EffW'(MaxStreams);
    end
    slot_inc = EffW'(slot_q) + EffW'(1);
    slot_nx  = (slot_inc >= eff) ? '0 : slot_inc[SlotW-1:0];
    sel      = (CmpW'(slot_q) == CmpW'(sel_q));
  end

  always_comb begin
    fin_ext    = (phase_q == iafd_pkg::PhCnt3);
    fin_count  = fin_ext ? cnt_q : 12'd0;
    fin_pcm    = (cpf_q >= 2'd2) ? {fin_count, 2'b00} : {1'b0, fin_count, 1'b0};
    fin_size   = fin_ext ? hdr_q : {data_byte_i[4:0], hdr_q[7:0]};
    fin_pre    = fin_ext ? 15'd6 : 15'd2;
    fin_need   = {1'b0, fin_pcm} + fin_pre;
    fin_bad    = ({2'b00, fin_size} < fin_need);
    fin_left_w = {2'b00, fin_size} - fin_pre;
    fin_left   = fin_left_w[12:0];
    fin_mpeg   = fin_left - fin_pcm[12:0];
    in_pcm     = ({1'b0, left_q} <= pcm_q);
    last       = (left_q == 13'd1);
  end

  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    cnt_d   = cnt_q;
    big_d   = big_q;
    pcm_d   = pcm_q;
    left_d  = left_q;
    slot_d  = slot_q;
    low_d   = low_q;
    err_d   = err_q;
    do_fin  = 1'b0;
    push_o  = '0;

    if (take_i) begin
      if (err_q) begin
        push_o.valid    = 1'b1;
        push_o.rec.kind = iafd_pkg::KindErr;
      end else begin
        unique case (phase_q)
          iafd_pkg::PhHdrHi: begin
            hdr_d = {data_byte_i[4:0], hdr_q[7:0]};
            if (data_byte_i[7]) begin
              cnt_d   = '0;
              big_d   = 1'b0;
              phase_d = iafd_pkg::PhCnt0;
            end else begin
              do_fin = 1'b1;
            end
          end
          iafd_pkg::PhCnt0: begin
            cnt_d[7:0] = data_byte_i;
            phase_d    = iafd_pkg::PhCnt1;
          end
          iafd_pkg::PhCnt1: begin
            cnt_d[11:8] = data_byte_i[3:0];
            big_d       = big_q | (data_byte_i[7:4] != 4'd0);
            phase_d     = iafd_pkg::PhCnt2;
          end
          iafd_pkg::PhCnt2: begin
            big_d   = big_q | (data_byte_i != 8'd0);
            phase_d = iafd_pkg::PhCnt3;
          end
          iafd_pkg::PhCnt3: begin
            phase_d = iafd_pkg::PhBody;
            if (big_q || (data_byte_i != 8'd0)) begin
              err_d           = 1'b1;
              push_o.valid    = 1'b1;
              push_o.rec.kind = iafd_pkg::KindErr;
            end else begin
              do_fin = 1'b1;
            end
          end
          iafd_pkg::PhBody: begin
            left_d = left_q - 13'd1;
            if (last) begin
              slot_d  = slot_nx;
              phase_d = iafd_pkg::PhHdrLo;
            end
            if (in_pcm) begin
              if (!left_q[0]) begin
                low_d = data_byte_i;
              end else if (sel) begin
                push_o.valid    = 1'b1;
                push_o.rec.kind = iafd_pkg::KindPcm;
                push_o.rec.data = {data_byte_i, low_q};
                push_o.rec.last = last;
              end
            end else if (sel) begin
              push_o.valid    = 1'b1;
              push_o.rec.kind = iafd_pkg::KindMpeg;
              push_o.rec.data = {8'd0, data_byte_i};
              push_o.rec.last = last;
            end
          end
          default: begin
            hdr_d   = {5'd0, data_byte_i};
            phase_d = iafd_pkg::PhHdrHi;
          end
        endcase

        if (do_fin) begin
          if (fin_bad) begin
            err_d           = 1'b1;
            push_o.valid    = 1'b1;
            push_o.rec.kind = iafd_pkg::KindErr;
          end else begin
            pcm_d  = fin_pcm;
            left_d = fin_left;
            if (fin_left == 13'd0) begin
              slot_d  = slot_nx;
              phase_d = iafd_pkg::PhHdrLo;
            end else begin
              phase_d = iafd_pkg::PhBody;
            end
            if (sel) begin
              push_o.valid      = 1'b1;
              push_o.rec.kind   = iafd_pkg::KindHdr;
              push_o.rec.count  = fin_count;
              push_o.rec.length = fin_mpeg;
              push_o.rec.last   = (fin_left == 13'd0);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= iafd_pkg::PhHdrLo;
      hdr_q   <= '0;
      cnt_q   <= '0;
      big_q   <= 1'b0;
      pcm_q   <= '0;
      left_q  <= '0;
      slot_q  <= '0;
      low_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      cnt_q   <= cnt_d;
      big_q   <= big_d;
      pcm_q   <= pcm_d;
      left_q  <= left_d;
      slot_q  <= slot_d;
      low_q   <= low_d;
      err_q   <= err_d;
    end
  end

  assign stat_o.error = err_q;
  assign stat_o.phase = phase_q;

endmodule

`default_nettype wire

### design/iafd_queue.sv
// ----------------------------------------------------------------------------
// Deframer result queue
// Two-entry queue of result records and the output field formatting.
// ----------------------------------------------------------------------------
`default_nettype none

module iafd_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  iafd_pkg::push_t         push_i,
  output logic                    full_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              out_kind_o,
  output logic [7:0]              mpeg_byte_o,
  output logic signed [15:0]      pcm_sample_o,
  output logic [11:0]             pcm_count_o,
  output logic [12:0]             mpeg_length_o,
  output logic                    frame_last_o
);

  localparam int PtrW = $clog2(iafd_pkg::QDepth);
  localparam int CntW = $clog2(iafd_pkg::QDepth + 1);

  iafd_pkg::rec_t mem_q [iafd_pkg::QDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  iafd_pkg::rec_t  head;

  assign full_o      = (cnt_q == CntW'(iafd_pkg::QDepth));
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head        = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i.valid) begin
      wr_d = (wr_q == PtrW'(iafd_pkg::QDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(iafd_pkg::QDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i.valid && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push_i.valid) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.rec;
    end
  end

  always_comb begin
    out_kind_o    = head.kind;
    mpeg_byte_o   = (head.kind == iafd_pkg::KindMpeg) ? head.data[7:0] : 8'd0;
    pcm_sample_o  = (head.kind == iafd_pkg::KindPcm) ? head.data : 16'sd0;
    pcm_count_o   = head.count;
    mpeg_length_o = head.length;
    frame_last_o  = head.last;
  end

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// Deframer regression bench
// Feeds well-formed frames with random content through several register
// settings, checks every header, MPEG byte and PCM sample item against an
// in-bench model of the parser, and closes on a sticky error and noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int          Streams     = 8;
  localparam int unsigned HdrBytes    = 2;
  localparam int unsigned ExtHdrBytes = 6;
  localparam int unsigned MaxFrame    = 8191;
  localparam int unsigned MaxCount    = 4095;
  localparam int unsigned PhaseBytes  = 70;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned ReportLimit = 10;

  typedef enum {
    FrameSmall, FramePlainMax, FrameExtMax, FrameShortSize, FrameExtShort, FrameHugeCount
  } frame_shape_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  mbyte;
    logic [15:0] pcm;
    logic [11:0] count;
    logic [12:0] length;
    logic        last;
  } frame_item_t;

  localparam logic [7:0] Opening [29] = '{
    8'h02, 8'h00,
    8'h04, 8'h60, 8'hFF, 8'h00,
    8'h06, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h08, 8'h80, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
    8'h0A, 8'h80, 8'h01, 8'h00, 8'h00, 8'h00, 8'h5A, 8'hA5, 8'hFF
  };
  localparam logic [7:0] OpeningTail = 8'h7F;

  logic [3:0] plan_ch  [6] = '{4'd2, 4'd3, 4'd0, 4'd1, 4'd2, 4'd1};
  logic [3:0] plan_str [6] = '{4'd3, 4'd8, 4'd0, 4'd15, 4'd2, 4'd8};
  logic [3:0] plan_sel [6] = '{4'd2, 4'd7, 4'd0, 4'd5, 4'd3, 4'd0};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i = '0;
  logic [3:0]          cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [7:0]          data_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          out_kind_o;
  logic [7:0]          mpeg_byte_o;
  logic signed [15:0]  pcm_sample_o;
  logic [11:0]         pcm_count_o;
  logic [12:0]         mpeg_length_o;
  logic                frame_last_o;

  // parser model state
  logic [2:0]  ph       = iafd_pkg::PhHdrLo;
  logic [15:0] hdr_word = '0;
  logic [31:0] cnt_acc  = '0;
  logic [12:0] left     = '0;
  logic [2:0]  slot     = '0;
  logic [7:0]  low_b    = '0;
  logic        err      = 1'b0;

  logic [1:0]  chan_cfg   = 2'd1;
  logic [3:0]  stream_cfg = 4'd1;
  logic [2:0]  select_cfg = 3'd0;

  frame_item_t frame_items_q[$];
  frame_item_t want;
  logic [7:0]  tx_bytes[$];
  logic [7:0]  frame_buf[$];
  logic [7:0]  carry_bytes[$];

  int unsigned n_pushed     = 0;
  int unsigned n_accepted   = 0;
  int unsigned n_results    = 0;
  int unsigned n_mismatches = 0;
  int unsigned n_settings   = 0;
  int unsigned n_kind [4]   = '{0, 0, 0, 0};
  int unsigned tx_gap       = 0;
  int unsigned rx_wait      = 0;
  int unsigned rx_next      = 0;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;

  interleaved_audio_frame_deframer #(
    .MAX_STREAMS(Streams)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_kind_o    (out_kind_o),
    .mpeg_byte_o   (mpeg_byte_o),
    .pcm_sample_o  (pcm_sample_o),
    .pcm_count_o   (pcm_count_o),
    .mpeg_length_o (mpeg_length_o),
    .frame_last_o  (frame_last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("interleaved_audio_frame_deframer regression: fail");
    $finish;
  end

  function automatic int unsigned idle_draw(input bit calm);
    if (calm || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  function automatic int unsigned active_streams();
    int unsigned n;
    n = 32'(stream_cfg);
    if (n == 0) n = 1;
    if (n > Streams) n = Streams;
    return n;
  endfunction

  function automatic frame_item_t make_item(input logic [1:0] k, input logic [7:0] mb,
                                            input logic [15:0] s, input logic [11:0] c,
                                            input logic [12:0] l, input logic lst);
    frame_item_t it;
    it.kind   = k;
    it.mbyte  = mb;
    it.pcm    = s;
    it.count  = c;
    it.length = l;
    it.last   = lst;
    return it;
  endfunction

  task automatic close_frame();
    if (int'(slot) + 1 >= active_streams()) slot = '0;
    else slot = slot + 3'd1;
    ph = iafd_pkg::PhHdrLo;
  endtask

  task automatic finish_header(input int unsigned cnt, input int unsigned pre, input bit sel);
    int unsigned size, pcm;
    size = 32'(hdr_word[12:0]);
    pcm  = 2 * cnt * ((chan_cfg >= 2) ? 2 : 1);
    if (size < pre + pcm) begin
      err = 1'b1;
      frame_items_q.push_back(make_item(iafd_pkg::KindErr, '0, '0, '0, '0, 1'b0));
    end else begin
      cnt_acc = pcm;
      left    = 13'(size - pre);
      if (left == 0) close_frame();
      else ph = iafd_pkg::PhBody;
      if (sel)
        frame_items_q.push_back(make_item(iafd_pkg::KindHdr, '0, '0, 12'(cnt),
                                          13'(size - pre - pcm), left == 0));
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    bit          sel, in_pcm, last;
    int unsigned prev;
    sel = (slot == select_cfg);
    if (err) begin
      frame_items_q.push_back(make_item(iafd_pkg::KindErr, '0, '0, '0, '0, 1'b0));
    end else if (ph == iafd_pkg::PhHdrHi) begin
      hdr_word[15:8] = b;
      if (hdr_word[15]) begin
        cnt_acc = '0;
        ph = iafd_pkg::PhCnt0;
      end else begin
        finish_header(0, HdrBytes, sel);
      end
    end else if (ph >= iafd_pkg::PhCnt0 && ph < iafd_pkg::PhBody) begin
      cnt_acc = cnt_acc | (32'(b) << (8 * (ph - iafd_pkg::PhCnt0)));
      ph = ph + 3'd1;
      if (ph == iafd_pkg::PhBody) begin
        if (cnt_acc > MaxCount) begin
          err = 1'b1;
          frame_items_q.push_back(make_item(iafd_pkg::KindErr, '0, '0, '0, '0, 1'b0));
        end else begin
          finish_header(cnt_acc, ExtHdrBytes, sel);
        end
      end
    end else if (ph == iafd_pkg::PhBody) begin
      prev   = 32'(left);
      in_pcm = (prev <= cnt_acc);
      left   = left - 13'd1;
      last   = (left == 0);
      if (last) close_frame();
      if (in_pcm) begin
        if (!prev[0]) low_b = b;
        else if (sel)
          frame_items_q.push_back(make_item(iafd_pkg::KindPcm, '0, {b, low_b}, '0, '0, last));
      end else if (sel) begin
        frame_items_q.push_back(make_item(iafd_pkg::KindMpeg, b, '0, '0, '0, last));
      end
    end else begin
      hdr_word = {8'h00, b};
      ph = iafd_pkg::PhHdrHi;
    end
  endtask

  // input side: present the next byte, hold it while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= '0;
      tx_gap      <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        deframe_byte(data_byte_i);
        n_accepted++;
      end
      if (in_valid_i && in_stall_o) begin
        in_valid_i <= 1'b1;
      end else if (tx_gap != 0) begin
        in_valid_i <= 1'b0;
        tx_gap     <= tx_gap - 1;
      end else if (tx_bytes.size() != 0) begin
        in_valid_i  <= 1'b1;
        data_byte_i <= tx_bytes.pop_front();
        tx_gap      <= idle_draw(tx_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side: compare each item with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
    end else begin
      rx_next = rx_wait;
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        n_kind[out_kind_o]++;
        if (frame_items_q.size() == 0) begin
          if (n_mismatches < ReportLimit)
            $display("unexpected item: kind %0d byte %0h pcm %0d count %0d length %0d last %0b",
                     out_kind_o, mpeg_byte_o, pcm_sample_o, pcm_count_o, mpeg_length_o,
                     frame_last_o);
          n_mismatches++;
        end else begin
          want = frame_items_q.pop_front();
          if (out_kind_o !== want.kind || mpeg_byte_o !== want.mbyte ||
              pcm_sample_o !== want.pcm || pcm_count_o !== want.count ||
              mpeg_length_o !== want.length || frame_last_o !== want.last) begin
            if (n_mismatches < ReportLimit)
              $display({"mismatch at item %0d (expected/actual): kind %0d/%0d byte %0h/%0h ",
                        "pcm %0d/%0d count %0d/%0d length %0d/%0d last %0b/%0b"},
                       n_results, want.kind, out_kind_o, want.mbyte, mpeg_byte_o,
                       $signed(want.pcm), pcm_sample_o, want.count, pcm_count_o,
                       want.length, mpeg_length_o, want.last, frame_last_o);
            n_mismatches++;
          end
        end
        rx_next = idle_draw(rx_calm);
      end
      if (rx_next != 0) begin
        out_stall_i <= 1'b1;
        rx_wait = rx_next - 1;
      end else begin
        out_stall_i <= 1'b0;
        rx_wait = 0;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    n_pushed++;
  endtask

  task automatic settle();
    while (n_accepted != n_pushed || frame_items_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      iafd_pkg::CfgChannels: chan_cfg   = val[1:0];
      iafd_pkg::CfgStreams:  stream_cfg = val;
      iafd_pkg::CfgSelect:   select_cfg = val[2:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(input logic [3:0] ch, input logic [3:0] str,
                               input logic [3:0] sel);
    write_reg(iafd_pkg::CfgChannels, ch);
    write_reg(iafd_pkg::CfgStreams, str);
    write_reg(iafd_pkg::CfgSelect, sel);
    n_settings++;
  endtask

  task automatic build_frame(input frame_shape_e shape, output int unsigned hdr_len);
    int unsigned ch, cnt, mlen, size;
    bit          ext;
    logic [31:0] cword;
    logic [15:0] hw;
    frame_buf.delete();
    ch   = (chan_cfg >= 2) ? 2 : 1;
    ext  = 1'($urandom_range(0, 1));
    cnt  = 0;
    mlen = 0;
    case (shape)
      FrameSmall: begin
        if (ext && $urandom_range(0, 3) != 0) cnt = $urandom_range(1, 6);
        if ($urandom_range(0, 4) != 0) mlen = $urandom_range(1, 16);
      end
      FramePlainMax: begin
        ext  = 1'b0;
        mlen = MaxFrame - HdrBytes;
      end
      FrameExtMax: begin
        ext  = 1'b1;
        cnt  = (MaxFrame - ExtHdrBytes) / (2 * ch);
        mlen = MaxFrame - ExtHdrBytes - 2 * cnt * ch;
      end
      FrameShortSize: ext = 1'b0;
      FrameExtShort: begin
        ext = 1'b1;
        cnt = $urandom_range(0, 6);
      end
      default: ext = 1'b1;
    endcase
    hdr_len = ext ? ExtHdrBytes : HdrBytes;
    size    = hdr_len + 2 * cnt * ch + mlen;
    cword   = cnt;
    if (shape == FrameShortSize) size = $urandom_range(0, HdrBytes - 1);
    if (shape == FrameExtShort) size = $urandom_range(0, size - 1);
    if (shape == FrameHugeCount) begin
      cword = $urandom_range(MaxCount + 1, 32'hFFFF_FFFF);
      size  = $urandom_range(0, MaxFrame);
    end
    hw = {ext, 2'($urandom_range(0, 3)), 13'(size)};
    frame_buf.push_back(hw[7:0]);
    frame_buf.push_back(hw[15:8]);
    if (ext) begin
      frame_buf.push_back(cword[7:0]);
      frame_buf.push_back(cword[15:8]);
      frame_buf.push_back(cword[23:16]);
      frame_buf.push_back(cword[31:24]);
    end
    if (shape == FrameSmall || shape == FramePlainMax || shape == FrameExtMax)
      repeat (size - hdr_len) frame_buf.push_back(8'($urandom));
  endtask

  // fill a phase with frames; sometimes cut the last one inside its body
  task automatic send_frames(input int unsigned budget);
    int unsigned hl, cut, n;
    n = 0;
    while (carry_bytes.size() != 0) begin
      queue_byte(carry_bytes.pop_front());
      n++;
    end
    while (n < budget) begin
      build_frame(FrameSmall, hl);
      cut = frame_buf.size();
      if (n + cut > budget && cut > hl + 1 && $urandom_range(0, 1) != 0)
        cut = $urandom_range(hl + 1, frame_buf.size() - 1);
      for (int i = 0; i < frame_buf.size(); i++) begin
        if (i < cut) queue_byte(frame_buf[i]);
        else carry_bytes.push_back(frame_buf[i]);
      end
      n += cut;
    end
  endtask

  initial begin : stimulus
    int unsigned hl;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    n_settings++;
    foreach (Opening[i]) queue_byte(Opening[i]);
    queue_byte(OpeningTail);
    settle();

    foreach (plan_ch[i]) begin
      apply_setting(plan_ch[i], plan_str[i], plan_sel[i]);
      tx_calm = (i == 2);
      rx_calm = (i == 4);
      send_frames(PhaseBytes);
      settle();
    end

    repeat (4) begin
      apply_setting(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)));
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      send_frames(PhaseBytes);
      settle();
    end

    // flush any cut frame, then break the stream and keep feeding noise
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    while (carry_bytes.size() != 0) queue_byte(carry_bytes.pop_front());
    case ($urandom_range(0, 2))
      0:       build_frame(FrameShortSize, hl);
      1:       build_frame(FrameExtShort, hl);
      default: build_frame(FrameHugeCount, hl);
    endcase
    foreach (frame_buf[i]) queue_byte(frame_buf[i]);
    repeat (40) queue_byte(8'($urandom));
    settle();

    $display("covered %0d stream bytes and %0d items over %0d register settings",
             n_accepted, n_results, n_settings);
    $display("items by kind: %0d headers, %0d mpeg bytes, %0d pcm samples, %0d errors",
             n_kind[iafd_pkg::KindHdr], n_kind[iafd_pkg::KindMpeg],
             n_kind[iafd_pkg::KindPcm], n_kind[iafd_pkg::KindErr]);
    if (n_mismatches == 0 && frame_items_q.size() == 0) begin
      $display("interleaved_audio_frame_deframer regression: pass");
    end else begin
      $display("%0d mismatches, %0d items still awaited", n_mismatches, frame_items_q.size());
      $display("interleaved_audio_frame_deframer regression: fail");
    end
    $finish;
  end

endmodule
